// ===== design/interpolating_sample_player_assert.svh =====
// ----------------------------------------------------------------------------
// interpolating sample player assertion macros
// concurrent checks, clocked on clk_i and muted during reset
// ----------------------------------------------------------------------------
`ifndef INTERPOLATING_SAMPLE_PLAYER_ASSERT_SVH
`define INTERPOLATING_SAMPLE_PLAYER_ASSERT_SVH

// same-cycle implication
`define ISP_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isp assertion failed");

// next-cycle implication
`define ISP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isp assertion failed");

`endif

// ===== design/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg
// shared constants, codes and types of the interpolating sample player
// ----------------------------------------------------------------------------
`default_nettype none

package isp_pkg;

  localparam int SLOTS       = 4;
  localparam int SLOT_DEPTH  = 4096;
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 16;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ADDR_W  = $clog2(SLOT_DEPTH);
  localparam int LEN_W   = ADDR_W + 1;
  localparam int MEM_AW  = SLOT_W + ADDR_W;
  localparam int MEM_DEPTH = SLOTS * SLOT_DEPTH;
  localparam int CH_W    = 1;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = ADDR_W + FRAC_W;
  localparam int POS_W   = 40;
  localparam int SPEED_W = 24;
  localparam int V_W     = SAMPLE_BITS + 6;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_LENGTH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_HERMITE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_PLAYED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_GATED  = 2'd2
  } status_e;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_EMPTY = 2'd1;

  typedef struct packed {
    logic       start;
    logic [1:0] mode;
  } isp_ctl_t;

endpackage

`default_nettype wire

// ===== design/isp_interp.sv =====
// ----------------------------------------------------------------------------
// isp_interp
// horner sequencer for linear and hermite interpolation (none passes y1 through), one mac step a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module isp_interp import isp_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire isp_ctl_t                      ctl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] y_i [4],
  input  wire logic [FRAC_W-1:0]             frac_i,
  output logic                               done_o,
  output logic signed [SAMPLE_BITS-1:0]      sample_o
);

  typedef enum logic [2:0] {
    I_IDLE = 3'b001,
    I_STEP = 3'b010,
    I_DONE = 3'b100
  } ist_e;

  localparam logic signed [V_W-1:0] SMAX = V_W'((1 << (SAMPLE_BITS-1)) - 1);
  localparam logic signed [V_W-1:0] SMIN = -V_W'(1 << (SAMPLE_BITS-1));

  ist_e                    state_q, state_d;
  logic [1:0]              left_q, left_d;
  logic [1:0]              mode_q, mode_d;
  logic signed [V_W-1:0]   v_q, v_d, a2_q, a2_d, a1_q, a1_d, a0_q, a0_d;

  logic signed [V_W-1:0]   y0e, y1e, y2e, y3e, d12, a3, add_w, vp, res;
  logic signed [V_W+FRAC_W:0] prod_w, rnd_w;

  assign y0e = V_W'(y_i[0]);
  assign y1e = V_W'(y_i[1]);
  assign y2e = V_W'(y_i[2]);
  assign y3e = V_W'(y_i[3]);
  assign d12 = y1e - y2e;
  assign a3  = (y3e - y0e) + d12 + (d12 <<< 1);

  // one mac step: floor((v*f + half) / 2^16) + coefficient
  assign prod_w = v_q * $signed({1'b0, frac_i});
  assign rnd_w  = prod_w + (V_W+FRAC_W+1)'(1 << (FRAC_W-1));

  always_comb begin
    unique case (left_q)
      2'd3:    add_w = a2_q;
      2'd2:    add_w = a1_q;
      default: add_w = a0_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    left_d  = left_q;
    mode_d  = mode_q;
    v_d     = v_q;
    a2_d    = a2_q;
    a1_d    = a1_q;
    a0_d    = a0_q;
    unique case (state_q)
      I_IDLE: begin
        if (ctl_i.start) begin
          mode_d = ctl_i.mode;
          a2_d   = (y0e <<< 1) - (y1e <<< 2) - y1e + (y2e <<< 2) - y3e;
          a1_d   = y2e - y0e;
          unique case (ctl_i.mode)
            MODE_HERMITE: begin
              v_d = a3; a0_d = y1e <<< 1; left_d = 2'd3; state_d = I_STEP;
            end
            MODE_LINEAR: begin
              v_d = y2e - y1e; a0_d = y1e; left_d = 2'd1; state_d = I_STEP;
            end
            default: begin
              v_d = y1e; a0_d = y1e; left_d = 2'd0; state_d = I_DONE;
            end
          endcase
        end
      end
      I_STEP: begin
        v_d    = $signed(rnd_w[FRAC_W +: V_W]) + add_w;
        left_d = left_q - 2'd1;
        if (left_q == 2'd1) begin
          state_d = I_DONE;
        end
      end
      I_DONE: begin
        state_d = I_IDLE;
      end
      default: state_d = I_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= I_IDLE;
      left_q  <= 2'd0;
      mode_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      mode_q  <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q  <= v_d;
    a2_q <= a2_d;
    a1_q <= a1_d;
    a0_q <= a0_d;
  end

  assign vp  = v_q + V_W'(1);
  assign res = (mode_q == MODE_HERMITE) ? (vp >>> 1) : v_q;

  always_comb begin
    if (res > SMAX) begin
      sample_o = SMAX[SAMPLE_BITS-1:0];
    end else if (res < SMIN) begin
      sample_o = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sample_o = res[SAMPLE_BITS-1:0];
    end
  end

  assign done_o = (state_q == I_DONE);

endmodule

`default_nettype wire

// ===== design/interpolating_sample_player.sv =====
// sequence: a load item is taken on acceptance; a tick with gate low or an empty slot
//   goes clip, result; a played tick goes clip, addr, read, last, interp, result,
//   paced by the single read port of the sample memory (one neighbour per cycle)
//   and the shared horner multiplier (one step per cycle); result waits while output is held
// flow: one tick in flight; no new item is taken until the tick is back in idle
// reset: slot lengths, read positions, mode, empty value and control clear at once; payload and samples are unset
// ----------------------------------------------------------------------------
// interpolating_sample_player
// variable-speed playback of mono sample slots with none, linear or hermite
// interpolation; sample store in one synchronous memory
// ----------------------------------------------------------------------------
`default_nettype none

module interpolating_sample_player import isp_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // configuration write port
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_wdata_i,
  // input items
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // channel, slot, address, write_data, slot_length, speed, start_offset, gate,
  // restart, zero pad
  input  wire logic [103:0]  s_axis_tdata,
  // operation
  input  wire logic [1:0]    s_axis_tuser,
  // result items
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // sample_out, position, zero pad
  output logic [47:0]        m_axis_tdata,
  // status
  output logic [1:0]         m_axis_tuser
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLIP   = 7'b0000010,
    S_ADDR   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_LAST   = 7'b0010000,
    S_INTERP = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_e;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // input fields
  op_e                           in_op;
  logic [CH_W-1:0]               in_ch;
  logic [SLOT_W-1:0]             in_slot;
  logic [ADDR_W-1:0]             in_addr;
  logic signed [SAMPLE_BITS-1:0] in_wdata;
  logic [LEN_W-1:0]              in_len;
  logic signed [SPEED_W-1:0]     in_speed;
  logic [IDX_W-1:0]              in_off;
  logic                          in_gate, in_restart, acc;

  assign in_op      = op_e'(s_axis_tuser);
  assign in_ch      = s_axis_tdata[0];
  assign in_slot    = s_axis_tdata[2:1];
  assign in_addr    = s_axis_tdata[14:3];
  assign in_wdata   = s_axis_tdata[30:15];
  assign in_len     = s_axis_tdata[43:31];
  assign in_speed   = s_axis_tdata[67:44];
  assign in_off     = s_axis_tdata[95:68];
  assign in_gate    = s_axis_tdata[96];
  assign in_restart = s_axis_tdata[97];

  state_e                        state_q;
  logic [1:0]                    mode_q;
  logic signed [SAMPLE_BITS-1:0] empty_q;
  logic [LEN_W-1:0]              len_tab_q [SLOTS];
  logic signed [POS_W-1:0]       pos_q [CHANNELS];

  // latched tick
  logic [CH_W-1:0]               ch_q;
  logic [SLOT_W-1:0]             slot_q;
  logic signed [SPEED_W-1:0]     speed_q;
  logic [IDX_W-1:0]              off_q;
  logic                          gate_q;
  logic [LEN_W-1:0]              len_q;
  logic [IDX_W-1:0]              idx_q;
  logic [ADDR_W-1:0]             km1_q, kp1_q, kp2_q;

  // memory read sequencing
  logic [1:0]                    rd_j_q, rd_first, rd_last;
  logic                          cap_vld_q;
  logic [1:0]                    cap_j_q;
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic signed [SAMPLE_BITS-1:0] y_q [4];
  logic                          start_q;

  // result holding and output register
  logic signed [SAMPLE_BITS-1:0] res_sample_q;
  logic [IDX_W-1:0]              res_pos_q;
  status_e                       res_status_q;
  logic                          m_valid_q;
  logic [47:0]                   m_data_q;
  logic [1:0]                    m_user_q;

  logic signed [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
  logic                          mem_we;
  logic [MEM_AW-1:0]             raddr;
  logic [ADDR_W-1:0]             k, rd_k;

  isp_ctl_t                      ip_ctl;
  logic                          ip_done;
  logic signed [SAMPLE_BITS-1:0] ip_sample;

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign mem_we        = acc && (in_op == OP_WRITE);
  assign k             = idx_q[IDX_W-1:FRAC_W];

  // window of neighbours read for each mode, y1 sits at the integer index
  always_comb begin
    unique case (mode_q)
      MODE_HERMITE: begin rd_first = 2'd0; rd_last = 2'd3; end
      MODE_LINEAR:  begin rd_first = 2'd1; rd_last = 2'd2; end
      default:      begin rd_first = 2'd1; rd_last = 2'd1; end
    endcase
  end

  always_comb begin
    unique case (rd_j_q)
      2'd0:    rd_k = km1_q;
      2'd1:    rd_k = k;
      2'd2:    rd_k = kp1_q;
      default: rd_k = kp2_q;
    endcase
  end
  assign raddr = {slot_q, rd_k};

  // sample memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[{in_slot, in_addr}] <= in_wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cap_vld_q) begin
      y_q[cap_j_q] <= rdata_q;
    end
  end

  // clip of position plus start offset to the slot, upper bound length - 1 lsb
  logic [LEN_W-1:0]       cur_len;
  logic signed [POS_W:0]  clip_sum;
  logic [IDX_W-1:0]       clip_hi, clip_idx;
  logic [LEN_W-1:0]       lenm1;

  assign cur_len  = len_tab_q[slot_q];
  assign lenm1    = cur_len - LEN_W'(1);
  assign clip_sum = {pos_q[ch_q][POS_W-1], pos_q[ch_q]} + $signed({13'b0, off_q});
  assign clip_hi  = {lenm1[ADDR_W-1:0], {FRAC_W{1'b1}}};

  always_comb begin
    if (clip_sum[POS_W]) begin
      clip_idx = '0;
    end else if (clip_sum > $signed({13'b0, clip_hi})) begin
      clip_idx = clip_hi;
    end else begin
      clip_idx = clip_sum[IDX_W-1:0];
    end
  end

  // wrapped neighbours around the integer index
  logic [LEN_W-1:0] kp1_w, kp2_w, kp2_s, lm1_w;
  logic [ADDR_W-1:0] kp1_n, kp2_n, km1_n;

  assign kp1_w = {1'b0, k} + LEN_W'(1);
  assign kp2_w = {1'b0, k} + LEN_W'(2);
  assign kp2_s = kp2_w - len_q;
  assign lm1_w = len_q - LEN_W'(1);

  always_comb begin
    kp1_n = (kp1_w == len_q) ? '0 : kp1_w[ADDR_W-1:0];
    km1_n = (k == '0) ? lm1_w[ADDR_W-1:0] : k - ADDR_W'(1);
    if (kp2_w < len_q) begin
      kp2_n = kp2_w[ADDR_W-1:0];
    end else if (kp2_s < len_q) begin
      kp2_n = kp2_s[ADDR_W-1:0];
    end else begin
      // single-word slot
      kp2_n = '0;
    end
  end

  // position advance with saturation at the 40-bit limits
  logic signed [POS_W:0]   adv_sum;
  logic signed [POS_W-1:0] adv_pos;

  assign adv_sum = {pos_q[ch_q][POS_W-1], pos_q[ch_q]} + (POS_W+1)'(speed_q);

  always_comb begin
    if (adv_sum[POS_W] != adv_sum[POS_W-1]) begin
      adv_pos = adv_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      adv_pos = adv_sum[POS_W-1:0];
    end
  end

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MODE_NONE;
      empty_q   <= '0;
      len_tab_q <= '{default: '0};
      pos_q     <= '{default: '0};
      rd_j_q    <= '0;
      cap_vld_q <= 1'b0;
      cap_j_q   <= '0;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MODE:  mode_q  <= cfg_wdata_i[1:0];
          CFG_EMPTY: empty_q <= cfg_wdata_i;
          default:   ;
        endcase
      end

      cap_vld_q <= (state_q == S_READ);
      cap_j_q   <= rd_j_q;
      start_q   <= (state_q == S_LAST);

      // output register: load a new result or drop the one taken
      if (state_q == S_RESULT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            unique case (in_op)
              OP_TICK: begin
                if (in_restart) begin
                  pos_q[in_ch] <= '0;
                end
                state_q <= S_CLIP;
              end
              OP_LENGTH: begin
                len_tab_q[in_slot] <= (in_len > LEN_W'(SLOT_DEPTH)) ?
                                      LEN_W'(SLOT_DEPTH) : in_len;
              end
              default: ;
            endcase
          end
        end
        S_CLIP: begin
          state_q <= (!gate_q || cur_len == '0) ? S_RESULT : S_ADDR;
        end
        S_ADDR: begin
          rd_j_q  <= rd_first;
          state_q <= S_READ;
        end
        S_READ: begin
          if (rd_j_q == rd_last) begin
            state_q <= S_LAST;
          end else begin
            rd_j_q <= rd_j_q + 2'd1;
          end
        end
        S_LAST: begin
          state_q <= S_INTERP;
        end
        S_INTERP: begin
          if (ip_done) begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            if (res_status_q == ST_PLAYED) begin
              pos_q[ch_q] <= adv_pos;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      ch_q    <= in_ch;
      slot_q  <= in_slot;
      speed_q <= in_speed;
      off_q   <= in_off;
      gate_q  <= in_gate;
    end
    if (state_q == S_CLIP) begin
      len_q <= cur_len;
      idx_q <= clip_idx;
      res_pos_q <= '0;
      if (!gate_q) begin
        res_sample_q <= '0;
        res_status_q <= ST_GATED;
      end else begin
        res_sample_q <= empty_q;
        res_status_q <= ST_EMPTY;
      end
    end
    if (state_q == S_ADDR) begin
      km1_q <= km1_n;
      kp1_q <= kp1_n;
      kp2_q <= kp2_n;
    end
    if (state_q == S_INTERP && ip_done) begin
      res_sample_q <= ip_sample;
      res_pos_q    <= idx_q;
      res_status_q <= ST_PLAYED;
    end
    if (state_q == S_RESULT && out_free) begin
      m_data_q <= {4'b0, res_pos_q, res_sample_q};
      m_user_q <= res_status_q;
    end
  end

  assign ip_ctl.start = start_q;
  assign ip_ctl.mode  = mode_q;

  isp_interp u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ip_ctl),
    .y_i      (y_q),
    .frac_i   (idx_q[FRAC_W-1:0]),
    .done_o   (ip_done),
    .sample_o (ip_sample)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`include "interpolating_sample_player_assert.svh"

  // a tick always moves on to the clip stage
  `ISP_ASSERT_NEXT(a_tick_to_clip, acc && in_op == OP_TICK, state_q == S_CLIP)
  // neighbour reads never run past the window of the mode
  `ISP_ASSERT(a_read_window, state_q == S_READ, rd_j_q <= rd_last)
  // the interpolator finishes only while it is awaited
  `ISP_ASSERT(a_done_in_interp, ip_done, state_q == S_INTERP)
  // the clipped integer index lies inside the slot
  `ISP_ASSERT(a_index_in_slot, state_q == S_ADDR, {1'b0, k} < len_q)

endmodule

`default_nettype wire
